// ===== hw/rtl/sd128_pkg.sv =====
// sd128_pkg: shared widths for the pipelined signed 128-bit divider.
// No dependencies; imported by signed_divide_128 and its checker.
`default_nettype none

package sd128_pkg;

    localparam int WIDE_BITS = 128;
    localparam int HALF_BITS = 64;

    typedef logic [HALF_BITS-1:0] t_half;
    typedef logic [WIDE_BITS-1:0] t_wide;

endpackage : sd128_pkg

`default_nettype wire

// ===== hw/rtl/signed_divide_128.sv =====
// signed_divide_128: fully pipelined signed restoring divider, one step per stage.
// Depends on sd128_pkg for the field widths.
//
//  channel   | handshake           | fields
//  ----------+---------------------+--------------------------------------------
//  operands  | start / busy        | i_dividend_low/high, i_divisor_low/high
//  results   | o_strobe (1 cycle)  | o_quotient_low/high, o_remainder_low/high
//
// One transaction accepted per cycle; busy is never raised.
// Stages from the accepting edge to the strobe: magnitude stage, one compare-subtract
// stage per quotient bit, sign-fix stage.
// Synchronous active-low reset clears the valid bits of every stage.
// Results cannot be held off, so the pipeline never stalls.
`default_nettype none

module signed_divide_128 #(
    parameter int OPERAND_BITS = 128
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  wire sd128_pkg::t_half i_dividend_low,
    input  wire sd128_pkg::t_half i_dividend_high,
    input  wire sd128_pkg::t_half i_divisor_low,
    input  wire sd128_pkg::t_half i_divisor_high,
    output logic               o_strobe,
    output sd128_pkg::t_half   o_quotient_low,
    output sd128_pkg::t_half   o_quotient_high,
    output sd128_pkg::t_half   o_remainder_low,
    output sd128_pkg::t_half   o_remainder_high
);
    import sd128_pkg::*;

    localparam int N = OPERAND_BITS;

    // ---------------- operand magnitudes ----------------
    t_wide          w_a_full;
    t_wide          w_b_full;
    logic [N-1:0]   w_a;
    logic [N-1:0]   w_b;
    logic [N-1:0]   w_a_abs;
    logic [N-1:0]   w_b_abs;
    logic           w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    assign w_a_full = {i_dividend_high, i_dividend_low};
    assign w_b_full = {i_divisor_high, i_divisor_low};
    assign w_a      = w_a_full[N-1:0];
    assign w_b      = w_b_full[N-1:0];
    assign w_a_abs  = w_a[N-1] ? (~w_a + N'(1)) : w_a;
    assign w_b_abs  = w_b[N-1] ? (~w_b + N'(1)) : w_b;

    // stage k holds the state after k restoring steps
    logic           r_vld  [0:N];
    logic [N-1:0]   r_rem  [0:N];
    logic [N-1:0]   r_aq   [0:N];   // dividend bits shift out the top, quotient bits in
    logic [N-1:0]   r_den  [0:N];
    logic           r_nega [0:N];
    logic           r_negq [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= w_accept;
        end
        r_rem[0]  <= '0;
        r_aq[0]   <= w_a_abs;
        r_den[0]  <= w_b_abs;
        r_nega[0] <= w_a[N-1];
        r_negq[0] <= w_a[N-1] ^ w_b[N-1];
    end

    // ---------------- restoring steps ----------------
    // For a nonzero divisor the remainder stays below the divisor magnitude (at most 2^(N-1)),
    // so the shifted partial remainder always fits in N bits.
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [N-1:0] w_shift;
        logic [N:0]   w_diff;
        logic         w_take;
        logic [N-1:0] n_rem;
        logic [N-1:0] n_aq;

        assign w_shift = {r_rem[k][N-2:0], r_aq[k][N-1]};
        assign w_diff  = {1'b0, w_shift} - {1'b0, r_den[k]};
        assign w_take  = !w_diff[N];
        assign n_rem   = w_take ? w_diff[N-1:0] : w_shift;
        assign n_aq    = {r_aq[k][N-2:0], w_take};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= n_rem;
            r_aq[k+1]   <= n_aq;
            r_den[k+1]  <= r_den[k];
            r_nega[k+1] <= r_nega[k];
            r_negq[k+1] <= r_negq[k];
        end
    end

    // ---------------- sign fix and output ----------------
    logic [N-1:0]   w_q_fin;
    logic [N-1:0]   w_r_fin;
    t_wide          w_q_ext;
    t_wide          w_r_ext;
    logic           r_strobe;
    t_wide          r_quot;
    t_wide          r_rmdr;

    assign w_q_fin = r_negq[N] ? (~r_aq[N] + N'(1)) : r_aq[N];
    assign w_r_fin = r_nega[N] ? (~r_rem[N] + N'(1)) : r_rem[N];
    assign w_q_ext = WIDE_BITS'($signed(w_q_fin));
    assign w_r_ext = WIDE_BITS'($signed(w_r_fin));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vld[N];
        end
        r_quot <= w_q_ext;
        r_rmdr <= w_r_ext;
    end

    assign o_strobe         = r_strobe;
    assign o_quotient_low   = r_quot[HALF_BITS-1:0];
    assign o_quotient_high  = r_quot[WIDE_BITS-1:HALF_BITS];
    assign o_remainder_low  = r_rmdr[HALF_BITS-1:0];
    assign o_remainder_high = r_rmdr[WIDE_BITS-1:HALF_BITS];

endmodule : signed_divide_128

`default_nettype wire

// ===== hw/rtl/sd128_check.sv =====
// sd128_check: port-level assertions for signed_divide_128, attached by bind.
// Depends on sd128_pkg for the field widths.
`default_nettype none

module sd128_check #(
    parameter int OPERAND_BITS = 128
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   start,
    input wire                   busy,
    input wire sd128_pkg::t_half i_dividend_low,
    input wire sd128_pkg::t_half i_dividend_high,
    input wire sd128_pkg::t_half i_divisor_low,
    input wire sd128_pkg::t_half i_divisor_high,
    input wire                   o_strobe,
    input wire sd128_pkg::t_half o_quotient_low,
    input wire sd128_pkg::t_half o_quotient_high,
    input wire sd128_pkg::t_half o_remainder_low,
    input wire sd128_pkg::t_half o_remainder_high
);
    import sd128_pkg::*;

    localparam int N   = OPERAND_BITS;
    localparam int LAT = OPERAND_BITS + 2;

    t_wide        w_a_full;
    t_wide        w_b_full;
    t_wide        w_q_out;
    t_wide        w_r_out;
    logic [N-1:0] w_a;
    t_wide        w_a_ext;
    logic         w_b_zero;
    logic         w_a_zero;

    assign w_a_full = {i_dividend_high, i_dividend_low};
    assign w_b_full = {i_divisor_high, i_divisor_low};
    assign w_q_out  = {o_quotient_high, o_quotient_low};
    assign w_r_out  = {o_remainder_high, o_remainder_low};
    assign w_a      = w_a_full[N-1:0];
    assign w_a_ext  = WIDE_BITS'($signed(w_a));
    assign w_a_zero = (w_a == '0);
    assign w_b_zero = (w_b_full[N-1:0] == '0);

    a_never_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised on a non-stalling pipeline");

    a_strobe_has_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result strobe without a transaction accepted LAT cycles earlier");

    a_div_by_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && w_b_zero) |-> ##LAT (o_strobe && w_r_out == $past(w_a_ext, LAT)))
        else $error("division by zero must return the dividend as remainder");

    a_zero_dividend : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && w_a_zero && !w_b_zero) |-> ##LAT
            (o_strobe && w_q_out == '0 && w_r_out == '0))
        else $error("zero dividend must give zero quotient and remainder");

endmodule : sd128_check

bind signed_divide_128 sd128_check #(.OPERAND_BITS(OPERAND_BITS)) u_sd128_check (.*);

`default_nettype wire
